### rtl/bmdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block matmul diagonal mask generator package
// Shared widths, register indexes, mask kinds and payload types.
// ----------------------------------------------------------------------------
package bmdm_pkg;

  localparam int SlotBits     = 16;
  localparam int MaxBlockLog2 = 7;

  localparam int SlotW    = 16;
  localparam int KindW    = 3;
  localparam int DiagW    = 8;
  localparam int HalfW    = DiagW / 2;
  localparam int BlkLogW  = 3;
  localparam int BpcLogW  = 4;
  localparam int BabyW    = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  localparam int BlkW  = MaxBlockLog2;
  localparam int PosW  = 2 * MaxBlockLog2;
  localparam int LgW   = $clog2(MaxBlockLog2 + 1);
  localparam int CmpW  = ((DiagW > BlkW + 1) ? DiagW : BlkW + 1) + 1;

  localparam logic [SlotW-1:0] SlotMask = SlotW'((64'd1 << SlotBits) - 64'd1);

  localparam logic [CfgIdxW-1:0] CfgIdxBlockLog2 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxBpcLog2   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgIdxBabySteps = CfgIdxW'(2);

  localparam logic [BlkLogW-1:0] BlockLog2Rst = BlkLogW'(4);
  localparam logic [BpcLogW-1:0] BpcLog2Rst   = BpcLogW'(0);
  localparam logic [BabyW-1:0]   BabyStepsRst = BabyW'(6);

  typedef enum logic [KindW-1:0] {
    KIND_SIGMA   = 3'd0,
    KIND_TAU     = 3'd1,
    KIND_PSI_K0  = 3'd2,
    KIND_PSI_WK  = 3'd3,
    KIND_PSI_WKD = 3'd4
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DiagW-1:0] diag_index;
    logic [SlotW-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic mask_bit;
    logic index_error;
  } out_t;

  typedef struct packed {
    logic [BlkLogW-1:0] block_log2;
    logic [BpcLogW-1:0] blocks_per_chunk_log2;
    logic [BabyW-1:0]   tau_baby_steps;
  } cfg_t;

  // One step of a restoring remainder: shift in one dividend bit, subtract if it fits.
  function automatic logic [BabyW-1:0] rem_step(input logic [BabyW-1:0] r,
                                                input logic             kb,
                                                input logic [BabyW-1:0] b);
    logic [BabyW:0] t;
    t = {r, kb};
    if (t >= {1'b0, b}) begin
      t = t - {1'b0, b};
    end
    return t[BabyW-1:0];
  endfunction

endpackage

### rtl/bmdm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block matmul diagonal mask generator datapath
// Three register stages: block position and range check with the upper half
// of the baby-step remainder, then the lower half and the tau rotation, then
// the per-kind compare into the output register.
// ----------------------------------------------------------------------------
module bmdm_core import bmdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DiagW-1:0] k;
    logic [PosW-1:0]  p;
    logic [BabyW-1:0] rem;
    logic             err;
  } s1_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DiagW-1:0] k;
    logic [PosW-1:0]  p;
    logic [PosW-1:0]  q;
    logic             err;
  } s2_t;

  logic [LgW-1:0]   lg;
  logic [BlkW-1:0]  dm;
  logic [PosW:0]    dsq_full;
  logic [PosW-1:0]  msk;
  logic [PosW-1:0]  d_w;
  logic [PosW-1:0]  dm_w;
  logic [BabyW-1:0] b_eff;

  always_comb begin
    if (int'(cfg_i.block_log2) > MaxBlockLog2) begin
      lg = LgW'(MaxBlockLog2);
    end else begin
      lg = LgW'(cfg_i.block_log2);
    end
    dm       = BlkW'(((BlkW + 1)'(1) << lg) - (BlkW + 1)'(1));
    dsq_full = (PosW + 1)'(1) << {lg, 1'b0};
    msk      = PosW'(dsq_full - (PosW + 1)'(1));
    d_w      = PosW'(1) << lg;
    dm_w     = PosW'(dm);
    b_eff    = (cfg_i.tau_baby_steps == '0) ? BabyW'(1) : cfg_i.tau_baby_steps;
  end

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  out_t s3_d, s3_q;

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  logic [SlotW-1:0] slot_m;
  logic [SlotW-1:0] slot_sh;
  logic [CmpW-1:0]  k_c;
  logic [BabyW-1:0] r1;

  always_comb begin
    slot_m  = in_data_i.slot_index & SlotMask;
    slot_sh = slot_m >> cfg_i.blocks_per_chunk_log2;
    k_c     = CmpW'(in_data_i.diag_index);
    r1      = '0;
    for (int n = 0; n < HalfW; n++) begin
      r1 = rem_step(r1, in_data_i.diag_index[DiagW-1-n], b_eff);
    end
    s1_d.kind = in_data_i.kind;
    s1_d.k    = in_data_i.diag_index;
    s1_d.p    = PosW'(slot_sh) & msk;
    s1_d.rem  = r1;
    unique case (kind_e'(in_data_i.kind))
      KIND_SIGMA, KIND_PSI_WK, KIND_PSI_WKD: s1_d.err = k_c > CmpW'(dm);
      KIND_TAU:                              s1_d.err = k_c > CmpW'({dm, 1'b0});
      KIND_PSI_K0:                           s1_d.err = 1'b0;
      default:                               s1_d.err = 1'b1;
    endcase
  end

  logic [BabyW-1:0] r2;
  logic [DiagW-1:0] g;

  always_comb begin
    r2 = s1_q.rem;
    for (int n = HalfW; n < DiagW; n++) begin
      r2 = rem_step(r2, s1_q.k[DiagW-1-n], b_eff);
    end
    g         = s1_q.k - DiagW'(r2);
    s2_d.kind = s1_q.kind;
    s2_d.k    = s1_q.k;
    s2_d.p    = s1_q.p;
    s2_d.err  = s1_q.err;
    s2_d.q    = (s1_q.p - PosW'(g) + dm_w) & msk;
  end

  logic [PosW-1:0] k_w, pi, pj, qi, qj, col, req;
  logic            hit;

  always_comb begin
    k_w = PosW'(s2_q.k);
    pi  = s2_q.p & dm_w;
    pj  = s2_q.p >> lg;
    qi  = s2_q.q & dm_w;
    qj  = s2_q.q >> lg;
    col = '0;
    req = '0;
    hit = 1'b0;
    unique case (kind_e'(s2_q.kind))
      KIND_SIGMA: begin
        col = (s2_q.p + (k_w << lg)) & msk;
        req = pi + (((pi + pj) & dm_w) << lg);
        hit = col == req;
      end
      KIND_TAU: begin
        col = (s2_q.q + k_w - dm_w) & msk;
        req = ((qi + qj) & dm_w) + (qj << lg);
        hit = col == req;
      end
      KIND_PSI_K0: begin
        hit = 1'b1;
      end
      KIND_PSI_WK: begin
        col = (s2_q.p + k_w) & msk;
        req = ((pi + k_w) & dm_w) + (pj << lg);
        hit = col == req;
      end
      KIND_PSI_WKD: begin
        col = (s2_q.p + k_w - d_w) & msk;
        req = ((pi + k_w) & dm_w) + (pj << lg);
        hit = col == req;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    s3_d.mask_bit    = hit && !s2_q.err;
    s3_d.index_error = s2_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  a_err_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.mask_bit && out_data_o.index_error))
    else $error("mask bit set together with index error");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (s1_q.rem < b_eff))
    else $error("partial remainder not below baby-step count");

  a_s2_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("item lost between first and second stage");

  a_out_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> out_valid_o)
    else $error("item lost before output register");

  a_psi_k0_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3 && (s2_q.kind == KIND_PSI_K0))
      |=> (out_data_o.mask_bit && !out_data_o.index_error))
    else $error("all-ones kind produced a zero or an error");

endmodule

### rtl/block_matmul_diagonal_mask_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block matmul diagonal mask generator
// Produces one 0/1 slot of a permutation-diagonal mask per transfer.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while in_stall_o is low and returns one
// result per transfer, in order. The datapath has three stages: block position
// and range check, the baby-step remainder for tau split over the first two
// stages, and the per-kind compare in the last. Output stalls back up stage by
// stage, so empty stages still fill while the output waits. Configuration
// registers may only be written while no transfer is in flight.
module block_matmul_diagonal_mask_gen import bmdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgIdxBlockLog2: cfg_d.block_log2            = cfg_wdata_i[BlkLogW-1:0];
        CfgIdxBpcLog2:   cfg_d.blocks_per_chunk_log2 = cfg_wdata_i[BpcLogW-1:0];
        CfgIdxBabySteps: cfg_d.tau_baby_steps        = cfg_wdata_i[BabyW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_log2            <= BlockLog2Rst;
      cfg_q.blocks_per_chunk_log2 <= BpcLog2Rst;
      cfg_q.tau_baby_steps        <= BabyStepsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bmdm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagonal mask generator testbench
// Sends mask-slot requests over several register settings, including the
// extremes, and compares every result with a table entry or a behavioral mask calculation.
// A directed table comes first, followed by random requests with random idle
// bursts on both sides, one long output hold-off and a final phase with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import bmdm_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned SettleDelay = 5;
  localparam int unsigned DiagMax     = 254;
  localparam int unsigned NumDirected = 22;
  localparam int unsigned NumFixedCfg = 6;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned PhaseItems  = 55;

  localparam logic [KindW-1:0] KindSpare0 = KindW'(KIND_PSI_WKD) + KindW'(1);
  localparam logic [KindW-1:0] KindSpare1 = KindW'(KIND_PSI_WKD) + KindW'(2);
  localparam logic [KindW-1:0] KindSpare2 = KindW'(KIND_PSI_WKD) + KindW'(3);

  typedef struct packed {
    in_t  item;
    logic known;
    out_t want;
  } stim_row_t;

  // Rows are meant for the reset settings: d = 16, S = 1, six baby steps.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{'{KIND_PSI_K0,  8'd0,   16'h0000}, 1'b1, '{1'b1, 1'b0}},
    '{'{KIND_PSI_K0,  8'd254, 16'hFFFF}, 1'b1, '{1'b1, 1'b0}},
    '{'{KindSpare0,   8'd0,   16'h0000}, 1'b1, '{1'b0, 1'b1}},
    '{'{KindSpare1,   8'd254, 16'hFFFF}, 1'b1, '{1'b0, 1'b1}},
    '{'{KindSpare2,   8'd7,   16'h04D2}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_SIGMA,   8'd16,  16'h0000}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_SIGMA,   8'd254, 16'hFFFF}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_TAU,     8'd31,  16'h0000}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_TAU,     8'd254, 16'h1234}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_PSI_WK,  8'd16,  16'h0003}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_PSI_WKD, 8'd200, 16'h8000}, 1'b1, '{1'b0, 1'b1}},
    '{'{KIND_SIGMA,   8'd0,   16'h0000}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_SIGMA,   8'd15,  16'hFFFF}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_SIGMA,   8'd0,   16'h0011}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_TAU,     8'd0,   16'h0000}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_TAU,     8'd30,  16'hFFFF}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_TAU,     8'd6,   16'h012C}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_PSI_WK,  8'd0,   16'h0005}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_PSI_WK,  8'd15,  16'h00FF}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_PSI_WKD, 8'd0,   16'h0005}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_PSI_WKD, 8'd15,  16'h1000}, 1'b0, '{1'b0, 1'b0}},
    '{'{KIND_PSI_WKD, 8'd1,   16'h7FFF}, 1'b0, '{1'b0, 1'b0}}
  };

  localparam cfg_t FixedSettings [NumFixedCfg] = '{
    '{3'd1, 4'd0,  5'd1},
    '{3'd7, 4'd10, 5'd16},
    '{3'd0, 4'd15, 5'd0},
    '{3'd7, 4'd15, 5'd31},
    '{3'd2, 4'd3,  5'd3},
    '{3'd3, 4'd1,  5'd7}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgIdxBlockLog2;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;

  cfg_t        shadow_cfg = '{BlockLog2Rst, BpcLog2Rst, BabyStepsRst};
  out_t        expected_masks[$];
  logic        cur_known = 1'b0;
  out_t        cur_want  = '0;
  int unsigned taken_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hold_req  = 1'b0;

  block_matmul_diagonal_mask_gen dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic out_t predict_mask(in_t it, cfg_t c);
    int unsigned k, lg, d, dsq, bpc, p, i, j, b, g, dm1, shift, q, qi, qj, col, req;
    longint unsigned slot, in_chunk;
    out_t r;
    r   = '0;
    k   = it.diag_index;
    bpc = c.blocks_per_chunk_log2;
    lg  = (c.block_log2 > MaxBlockLog2) ? MaxBlockLog2 : c.block_log2;
    d   = 1 << lg;
    dsq = d * d;
    slot     = it.slot_index & SlotMask;
    in_chunk = slot & ((64'd1 << (bpc + 2 * lg)) - 64'd1);
    p = int'(in_chunk >> bpc);
    i = p & (d - 1);
    j = p >> lg;
    case (it.kind)
      KIND_SIGMA: begin
        if (k > d - 1) begin
          r.index_error = 1'b1;
        end else begin
          col = (p + d * k) % dsq;
          r.mask_bit = (col == i + d * ((i + j) & (d - 1)));
        end
      end
      KIND_TAU: begin
        if (k > 2 * d - 2) begin
          r.index_error = 1'b1;
        end else begin
          b     = (c.tau_baby_steps == 0) ? 1 : c.tau_baby_steps;
          g     = (k / b) * b;
          dm1   = (d - 1) % dsq;
          shift = (g % dsq + dsq - dm1) % dsq;
          q     = (p + dsq - shift) % dsq;
          qi    = q & (d - 1);
          qj    = q >> lg;
          col   = (q + k % dsq + dsq - dm1) % dsq;
          r.mask_bit = (col == ((qi + qj) & (d - 1)) + d * qj);
        end
      end
      KIND_PSI_K0: r.mask_bit = 1'b1;
      KIND_PSI_WK, KIND_PSI_WKD: begin
        if (k > d - 1) begin
          r.index_error = 1'b1;
        end else begin
          req = ((i + k) & (d - 1)) + d * j;
          if (it.kind == KIND_PSI_WK) begin
            col = (p + k) % dsq;
          end else begin
            col = (p + k + dsq - d % dsq) % dsq;
          end
          r.mask_bit = (col == req);
        end
      end
      default: r.index_error = 1'b1;
    endcase
    return r;
  endfunction

  function automatic in_t random_request(cfg_t c);
    in_t it;
    int unsigned d, kmax;
    d = 1 << c.block_log2;
    if ($urandom_range(0, 19) == 0) begin
      it.kind = KindW'($urandom_range(KindSpare0, KindSpare2));
    end else begin
      it.kind = KindW'($urandom_range(KIND_SIGMA, KIND_PSI_WKD));
    end
    case (it.kind)
      KIND_TAU:                              kmax = 2 * d - 2;
      KIND_SIGMA, KIND_PSI_WK, KIND_PSI_WKD: kmax = d - 1;
      default:                               kmax = DiagMax;
    endcase
    if (kmax > DiagMax || $urandom_range(0, 7) == 0) begin
      kmax = DiagMax;
    end
    it.diag_index = DiagW'($urandom_range(0, kmax));
    case ($urandom_range(0, 9))
      0:       it.slot_index = '0;
      1:       it.slot_index = SlotMask;
      default: it.slot_index = SlotW'($urandom);
    endcase
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(in_t it, logic known, out_t want);
    int unsigned mark;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    cur_known  = known;
    cur_want   = want;
    mark = taken_count;
    do @(negedge clk_i); while (taken_count == mark);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    case (idx)
      CfgIdxBlockLog2: shadow_cfg.block_log2            = data[BlkLogW-1:0];
      CfgIdxBpcLog2:   shadow_cfg.blocks_per_chunk_log2 = data[BpcLogW-1:0];
      CfgIdxBabySteps: shadow_cfg.tau_baby_steps        = data[BabyW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_masks.size() != 0) @(negedge clk_i);
    repeat (SettleDelay) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_masks = {expected_masks,
                          cur_known ? cur_want : predict_mask(in_data_i, shadow_cfg)};
        taken_count <= taken_count + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected transfer, actual mask_bit %0b index_error %0b",
                   $time, out_data_o.mask_bit, out_data_o.index_error);
          error_count++;
        end else begin
          want = expected_masks.pop_front();
          if (out_data_o.mask_bit !== want.mask_bit) begin
            $display("%0t: mask_bit expected %0b actual %0b",
                     $time, want.mask_bit, out_data_o.mask_bit);
            error_count++;
          end
          if (out_data_o.index_error !== want.index_error) begin
            $display("%0t: index_error expected %0b actual %0b",
                     $time, want.index_error, out_data_o.index_error);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    cfg_t        c;
    stim_row_t   row;
    int unsigned ph;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int unsigned n = 0; n < NumDirected; n++) begin
      row = DirectedRows[n];
      send_request(row.item, row.known, row.want);
    end
    in_valid_i = 1'b0;
    wait_drained();
    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph < NumFixedCfg) begin
        c = FixedSettings[ph];
        write_reg(CfgIdxBlockLog2,
                  {(CfgDataW - BlkLogW)'($urandom), c.block_log2});
        write_reg(CfgIdxBpcLog2,
                  {(CfgDataW - BpcLogW)'($urandom), c.blocks_per_chunk_log2});
        write_reg(CfgIdxBabySteps, c.tau_baby_steps);
      end else begin
        write_reg(CfgIdxBlockLog2, CfgDataW'($urandom));
        write_reg(CfgIdxBpcLog2, CfgDataW'($urandom));
        write_reg(CfgIdxBabySteps, CfgDataW'($urandom));
      end
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      if (ph == NumPhases - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_request(random_request(shadow_cfg), 1'b0, '0);
      end
      in_valid_i = 1'b0;
      wait_drained();
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bmdm_pkg.sv
rtl/bmdm_core.sv
rtl/block_matmul_diagonal_mask_gen.sv
test/testbench.sv
